// ===== rtl/hajf_pkg.sv =====
// hajf_pkg: shared types and constants for the hash anti-join filter
// no dependencies; imported by the filter core

package hajf_pkg;

   localparam int KEY_W = 64;
   localparam int KEY_FIELDS = 4;
   localparam int CFG_W = 3;
   localparam logic [CFG_W-1:0] COL_CNT_RESET = 3'd1;

   typedef logic [KEY_W-1:0] key_col_type;
   typedef key_col_type [KEY_FIELDS-1:0] key_array_type;

endpackage

// ===== rtl/hajf_ram.sv =====
// hajf_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module hajf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/hash_anti_join_filter_core.sv =====
// hash_anti_join_filter_core: set-difference filter over multi-column keys
// depends on hajf_pkg and hajf_ram

// Load words (op 0) add a key to a hashed set held in two memories, a slot
// table (valid + row) and a key table (one row of MAX_COLUMNS columns); probe
// words (op 1) report keep = 1 when the key is absent. Open addressing with
// linear probing, hash taken over key_0. After reset a clearing pass writes
// every slot, during which req_stall stays high; the column count register
// can still be written. One word at a time goes through the sequencer: from
// accept through S_SLOT and S_SLOT_CHK to S_DONE when the home slot is empty;
// an occupied slot adds S_KEY_CHK, which ends in S_DONE when the key is found
// or moves on to the next slot; each step waits on a registered memory read.
// A result waiting on rsp_stall holds the next word's finish step only.

module hash_anti_join_filter_core
   import hajf_pkg::*;
#(
   parameter int MAX_ROWS = 1024,
   parameter int HASH_SLOTS = 2048,
   parameter int MAX_COLUMNS = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_op,
   input  logic [KEY_W-1:0] req_key_0,
   input  logic [KEY_W-1:0] req_key_1,
   input  logic [KEY_W-1:0] req_key_2,
   input  logic [KEY_W-1:0] req_key_3,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_keep,
   output logic             rsp_inserted,
   output logic             rsp_table_full
);

   localparam int SLOT_W = $clog2(HASH_SLOTS);
   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int SMEM_W = ROW_W + 1;
   localparam int KMEM_W = KEY_W * MAX_COLUMNS;

   localparam logic [2:0] S_CLEAR    = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_SLOT     = 3'd2;
   localparam logic [2:0] S_SLOT_CHK = 3'd3;
   localparam logic [2:0] S_KEY_CHK  = 3'd4;
   localparam logic [2:0] S_DONE     = 3'd5;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HASH_SLOTS - 1);
   localparam logic [SLOT_W:0] LAST_PROBE = (SLOT_W + 1)'(HASH_SLOTS - 1);
   localparam logic [ROW_W:0] ROW_LIMIT = (ROW_W + 1)'(MAX_ROWS);

   logic [2:0]        state_ff, state_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W:0]   probes_ff, probes_in;
   logic [SLOT_W-1:0] free_slot_ff, free_slot_in;
   logic              free_ok_ff, free_ok_in;
   logic              found_ff, found_in;
   logic              op_ff, op_in;
   key_array_type     key_ff, key_in;
   logic [CFG_W-1:0]  col_ff;
   logic [ROW_W:0]    row_count_ff, row_count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              keep_ff, keep_in;
   logic              inserted_ff, inserted_in;
   logic              full_ff, full_in;

   logic              smem_we;
   logic [SLOT_W-1:0] smem_waddr;
   logic [SMEM_W-1:0] smem_wdata;
   logic [SMEM_W-1:0] smem_rdata;
   logic              kmem_we;
   logic [KMEM_W-1:0] kmem_wdata;
   logic [KMEM_W-1:0] kmem_rdata;
   logic [CFG_W-1:0]  eff_cols;
   logic              key_match;
   logic              out_free;
   logic              do_insert;
   logic [SLOT_W-1:0] home_slot;

   // fold key_0 down to a slot index, then bring it below the table size
   function automatic logic [SLOT_W-1:0] fold_hash(input logic [KEY_W-1:0] k);
      logic [SLOT_W-1:0] h;
      h = '0;
      for (int i = 0; i < KEY_W; i++) begin
         h[i % SLOT_W] = h[i % SLOT_W] ^ k[i];
      end
      if ({1'b0, h} >= (SLOT_W + 1)'(HASH_SLOTS)) begin
         h = SLOT_W'({1'b0, h} - (SLOT_W + 1)'(HASH_SLOTS));
      end
      return h;
   endfunction

   assign home_slot = fold_hash(req_key_0);

   // slot table: valid bit over row index
   hajf_ram #(.WIDTH(SMEM_W), .DEPTH(HASH_SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (smem_we),
      .wr_addr (smem_waddr),
      .wr_data (smem_wdata),
      .rd_addr (slot_ff),
      .rd_data (smem_rdata)
   );

   // key table: one row holds all stored columns
   hajf_ram #(.WIDTH(KMEM_W), .DEPTH(MAX_ROWS)) u_key_ram (
      .clock   (clock),
      .wr_en   (kmem_we),
      .wr_addr (row_count_ff[ROW_W-1:0]),
      .wr_data (kmem_wdata),
      .rd_addr (smem_rdata[ROW_W-1:0]),
      .rd_data (kmem_rdata)
   );

   // stored row image, columns past the key fields are zero
   always_comb begin
      kmem_wdata = '0;
      for (int c = 0; c < MAX_COLUMNS; c++) begin
         if (c < KEY_FIELDS) begin
            kmem_wdata[c*KEY_W +: KEY_W] = key_ff[c];
         end
      end
   end

   // effective column count: at least one, at most the stored and key columns
   always_comb begin
      int n;
      n = int'(col_ff);
      if (n < 1) n = 1;
      if (n > MAX_COLUMNS) n = MAX_COLUMNS;
      if (n > KEY_FIELDS) n = KEY_FIELDS;
      eff_cols = CFG_W'(n);
   end

   // compare the stored row against the latched key
   always_comb begin
      key_match = 1'b1;
      for (int c = 0; c < MAX_COLUMNS; c++) begin
         if (c < KEY_FIELDS && c < int'(eff_cols)) begin
            if (kmem_rdata[c*KEY_W +: KEY_W] != key_ff[c]) key_match = 1'b0;
         end
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign do_insert = (state_ff == S_DONE) && out_free && !op_ff && !found_ff
                      && free_ok_ff && (row_count_ff < ROW_LIMIT);

   // memory writes: clearing pass or insert
   always_comb begin
      smem_we = 1'b0;
      smem_waddr = free_slot_ff;
      smem_wdata = {1'b1, row_count_ff[ROW_W-1:0]};
      if (state_ff == S_CLEAR) begin
         smem_we = 1'b1;
         smem_waddr = clr_ff;
         smem_wdata = '0;
      end else if (do_insert) begin
         smem_we = 1'b1;
      end
   end
   assign kmem_we = do_insert;

   // sequencer
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      slot_in = slot_ff;
      probes_in = probes_ff;
      free_slot_in = free_slot_ff;
      free_ok_in = free_ok_ff;
      found_in = found_ff;
      op_in = op_ff;
      key_in = key_ff;
      row_count_in = row_count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      keep_in = keep_ff;
      inserted_in = inserted_ff;
      full_in = full_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_SLOT) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_op;
               key_in[0] = req_key_0;
               key_in[1] = req_key_1;
               key_in[2] = req_key_2;
               key_in[3] = req_key_3;
               slot_in = home_slot;
               probes_in = '0;
               found_in = 1'b0;
               free_ok_in = 1'b0;
               state_in = S_SLOT;
            end
         end
         S_SLOT: begin
            state_in = S_SLOT_CHK;
         end
         S_SLOT_CHK: begin
            if (!smem_rdata[SMEM_W-1]) begin
               free_slot_in = slot_ff;
               free_ok_in = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_KEY_CHK;
            end
         end
         S_KEY_CHK: begin
            if (key_match) begin
               found_in = 1'b1;
               state_in = S_DONE;
            end else if (probes_ff == LAST_PROBE) begin
               state_in = S_DONE;
            end else begin
               probes_in = probes_ff + 1'b1;
               slot_in = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
               state_in = S_SLOT;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               keep_in = op_ff && !found_ff;
               inserted_in = do_insert;
               full_in = !op_ff && !found_ff && !do_insert;
               if (do_insert) row_count_in = row_count_ff + 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         row_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         col_ff <= COL_CNT_RESET;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         row_count_ff <= row_count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) col_ff <= csr_wr_data;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      probes_ff <= probes_in;
      free_slot_ff <= free_slot_in;
      free_ok_ff <= free_ok_in;
      found_ff <= found_in;
      op_ff <= op_in;
      key_ff <= key_in;
      keep_ff <= keep_in;
      inserted_ff <= inserted_in;
      full_ff <= full_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_keep = keep_ff;
   assign rsp_inserted = inserted_ff;
   assign rsp_table_full = full_ff;

   // checks
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      row_count_ff <= ROW_LIMIT)
      else $error("row count past table size");

   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({keep_ff, inserted_ff, full_ff}))
      else $error("more than one result flag set");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      do_insert |=> row_count_ff == $past(row_count_ff) + 1'b1)
      else $error("row count not advanced on insert");

   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> req_stall && !rsp_valid_ff)
      else $error("activity during clearing pass");

   a_insert_flag: assert property (@(posedge clock) disable iff (reset)
      do_insert |=> rsp_valid_ff && inserted_ff)
      else $error("insert without inserted result");

endmodule
